// ===== rtl/sha_pkg.sv =====
// sha-256 hasher package: constants, round table, helper functions and shared types
// no dependencies
package sha_pkg;

    localparam int unsigned BlkBytes = 64;
    localparam int unsigned QDepth   = 4;
    localparam int unsigned QAw      = 2;

    typedef logic [31:0] t_word;

    typedef struct packed {
        logic [7:0] data;
        logic       fin;
    } t_byte_item;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_PAD,
        ST_LEN,
        ST_EMIT
    } t_state;

    function automatic t_word init_hash(input logic [2:0] i);
        t_word r;
        case (i)
            3'd0: r = 32'h6a09e667;
            3'd1: r = 32'hbb67ae85;
            3'd2: r = 32'h3c6ef372;
            3'd3: r = 32'ha54ff53a;
            3'd4: r = 32'h510e527f;
            3'd5: r = 32'h9b05688c;
            3'd6: r = 32'h1f83d9ab;
            default: r = 32'h5be0cd19;
        endcase
        return r;
    endfunction

    localparam t_word KTab [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic t_word rotr(input t_word x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ===== rtl/sha_in_queue.sv =====
// front end: short byte queue between the input port and the compression engine
// depends on sha_pkg
module sha_in_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  sha_pkg::t_byte_item i_item,
    output logic                o_full,
    output logic                o_valid,
    output sha_pkg::t_byte_item o_item,
    input  logic                i_take
);
    sha_pkg::t_byte_item r_mem [sha_pkg::QDepth];
    logic [sha_pkg::QAw-1:0] r_wp, r_rp;
    logic [sha_pkg::QAw:0]   r_cnt;
    logic wr, rd;

    assign o_full  = (r_cnt == 3'(sha_pkg::QDepth));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];
    assign wr = i_push && !o_full;
    assign rd = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) r_wp <= r_wp + 1'b1;
            if (rd) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (wr ? 1'b1 : 1'b0) - (rd ? 1'b1 : 1'b0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_item;
    end
endmodule

// ===== rtl/sha_core.sv =====
// back end: block packing, padding, 64-round compression and digest output
// depends on sha_pkg
module sha_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  sha_pkg::t_byte_item i_item,
    output logic                o_take,
    output logic                o_empty,
    input  logic                i_pop,
    output logic [31:0]         o_digest_word,
    output logic [2:0]          o_word_index,
    output logic                o_last_word
);
    sha_pkg::t_state r_st, n_st;
    sha_pkg::t_word  r_w [16];
    sha_pkg::t_word  r_h [8];
    sha_pkg::t_word  r_v [8];
    logic [60:0] r_cnt;
    logic [5:0]  r_pos;
    logic [5:0]  r_rnd;
    logic        r_fin;     // padding pending after this compression
    logic        r_lenblk;  // 0x80 marker placed; held until the digest is read
    logic [2:0]  r_oi;

    logic   take_byte, do_pad, do_len, start_comp;
    logic [7:0] wb;
    sha_pkg::t_word s0, s1, wnew, e1, ch, a0, mj, t1, t2;
    logic [63:0] bits;

    assign bits = {r_cnt, 3'b000};
    assign o_empty = (r_st != sha_pkg::ST_EMIT);
    assign o_digest_word = r_h[r_oi];
    assign o_word_index = r_oi;
    assign o_last_word = (r_oi == 3'd7);

    always_comb begin
        s0 = sha_pkg::rotr(r_w[1], 7) ^ sha_pkg::rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        s1 = sha_pkg::rotr(r_w[14], 17) ^ sha_pkg::rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        wnew = r_w[0] + s0 + r_w[9] + s1;
        e1 = sha_pkg::rotr(r_v[4], 6) ^ sha_pkg::rotr(r_v[4], 11) ^ sha_pkg::rotr(r_v[4], 25);
        ch = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        t1 = r_v[7] + e1 + ch + sha_pkg::KTab[r_rnd] + r_w[0];
        a0 = sha_pkg::rotr(r_v[0], 2) ^ sha_pkg::rotr(r_v[0], 13) ^ sha_pkg::rotr(r_v[0], 22);
        mj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t2 = a0 + mj;
    end

    always_comb begin
        n_st = r_st;
        take_byte = 1'b0;
        do_pad = 1'b0;
        do_len = 1'b0;
        start_comp = 1'b0;
        wb = i_item.data;
        case (r_st)
            sha_pkg::ST_LOAD: begin
                take_byte = i_valid;
                if (i_valid && (r_pos == 6'd63)) begin
                    start_comp = 1'b1;
                    n_st = sha_pkg::ST_ROUND;
                end else if (i_valid && i_item.fin) begin
                    n_st = sha_pkg::ST_PAD;
                end
            end
            sha_pkg::ST_PAD: begin
                // 0x80 then zero fill, one byte per cycle
                do_pad = 1'b1;
                wb = r_lenblk ? 8'h00 : 8'h80;
                if (r_pos == 6'd63) begin
                    start_comp = 1'b1;
                    n_st = sha_pkg::ST_ROUND;
                end else if (r_pos == 6'd55 && !(r_lenblk && r_pos == 6'd0)) begin
                    n_st = sha_pkg::ST_LEN;
                end
            end
            sha_pkg::ST_LEN: begin
                do_len = 1'b1;
                start_comp = 1'b1;
                n_st = sha_pkg::ST_ROUND;
            end
            sha_pkg::ST_ROUND: begin
                if (r_rnd == 6'd63) n_st = sha_pkg::ST_ADD;
            end
            sha_pkg::ST_ADD: begin
                if (r_fin) n_st = sha_pkg::ST_PAD;
                else if (r_lenblk) n_st = sha_pkg::ST_EMIT;
                else n_st = sha_pkg::ST_LOAD;
            end
            sha_pkg::ST_EMIT: begin
                if (i_pop && r_oi == 3'd7) n_st = sha_pkg::ST_LOAD;
            end
            default: n_st = sha_pkg::ST_LOAD;
        endcase
    end
    assign o_take = take_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= sha_pkg::ST_LOAD;
            r_cnt <= '0;
            r_pos <= '0;
            r_rnd <= '0;
            r_fin <= 1'b0;
            r_lenblk <= 1'b0;
            r_oi <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= sha_pkg::init_hash(3'(i));
        end else begin
            r_st <= n_st;
            if (take_byte) begin
                r_cnt <= r_cnt + 61'd1;
                r_pos <= r_pos + 6'd1;
                if (i_item.fin) r_fin <= 1'b1;
            end
            if (do_pad) begin
                r_pos <= r_pos + 6'd1;
                if (!r_lenblk) r_lenblk <= 1'b1;   // 0x80 placed
            end
            if (do_len) begin
                r_pos <= '0;
                r_fin <= 1'b0;
            end
            if (do_pad && r_pos == 6'd63) begin
                // length goes into a fresh block
                r_fin <= 1'b1;
            end
            if (r_st == sha_pkg::ST_ROUND) r_rnd <= r_rnd + 6'd1;
            if (r_st == sha_pkg::ST_ADD) begin
                r_rnd <= '0;
                for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
            end
            if (r_st == sha_pkg::ST_EMIT && i_pop) begin
                r_oi <= r_oi + 3'd1;
                if (r_oi == 3'd7) begin
                    for (int i = 0; i < 8; i++) r_h[i] <= sha_pkg::init_hash(3'(i));
                    r_cnt <= '0;
                    r_pos <= '0;
                    r_fin <= 1'b0;
                    r_lenblk <= 1'b0;
                end
            end
        end
    end

    // message words: byte packing and length insertion, then a shifting 16-word schedule window
    always_ff @(posedge i_clk) begin
        if (take_byte || do_pad) begin
            case (r_pos[1:0])
                2'd0: r_w[r_pos[5:2]] <= {wb, 24'h0};
                2'd1: r_w[r_pos[5:2]][23:16] <= wb;
                2'd2: r_w[r_pos[5:2]][15:8] <= wb;
                default: r_w[r_pos[5:2]][7:0] <= wb;
            endcase
        end
        if (do_len) begin
            r_w[14] <= bits[63:32];
            r_w[15] <= bits[31:0];
        end
        if (r_st == sha_pkg::ST_ROUND) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= wnew;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start_comp) begin
            for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
        end else if (r_st == sha_pkg::ST_ROUND) begin
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end
endmodule

// ===== rtl/sha256_message_hasher.sv =====
// sha-256 message hasher top level: input byte queue and compression back end
// depends on sha_pkg, sha_in_queue, sha_core
//
// usage:
//  input channel: push a message byte with i_push while o_full is low; set
//  i_final_byte on the last byte of the message.
//  result channel: while o_empty is low the next digest word is shown with
//  its index; i_pop takes it. eight words follow each final byte.
//  a four-entry queue takes bytes while the engine compresses, so a byte is
//  taken per cycle until the queue fills.
//  a full block is loaded byte by byte, then compressed by the rounds and the
//  chaining add (one round per cycle in the single round unit); padding adds
//  zero fill and one or two compressions.
//  while digest words wait unpopped the engine holds and the queue fills.
//  synchronous reset empties the queue, reloads the initial hash and clears
//  the byte count; no clearing pass is needed.
module sha256_message_hasher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [7:0]  i_message_byte,
    input  logic        i_final_byte,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    sha_pkg::t_byte_item in_item, q_item;
    logic q_valid, q_take;

    assign in_item.data = i_message_byte;
    assign in_item.fin  = i_final_byte;

    sha_in_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(i_push), .i_item(in_item),
        .o_full(o_full), .o_valid(q_valid), .o_item(q_item), .i_take(q_take)
    );

    sha_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .i_item(q_item),
        .o_take(q_take), .o_empty(o_empty), .i_pop(i_pop),
        .o_digest_word(o_digest_word), .o_word_index(o_word_index),
        .o_last_word(o_last_word)
    );

`ifndef SYNTH
    a_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && i_pop && !o_last_word) |=> (o_word_index == $past(o_word_index) + 3'd1))
        else $error("digest index did not advance");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_digest_word)))
        else $error("stalled digest word changed");
    a_no_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> !q_take)
        else $error("byte taken during digest output");
`endif
endmodule
